>>> design/ods_pkg.sv
// ods_pkg: shared constants, types and helper functions of the orbital density sampler
// no dependencies; imported by orbital_density_sampler, ods_sqrt, ods_div and ods_harm
package ods_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 9;
  localparam int CMP_W       = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam int SQRT_LAT = 32;
  localparam int DIV_LAT  = 32;
  localparam int HARM_LAT = 4;

  typedef enum logic [1:0] {
    REG_RADIUS_LIMIT = 2'd0,
    REG_DEGREE       = 2'd1,
    REG_ORDER        = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] DEG_S = 2'd0;
  localparam logic [1:0] DEG_P = 2'd1;
  localparam logic [1:0] DEG_D = 2'd2;
  localparam logic [1:0] DEG_F = 2'd3;

  localparam logic signed [2:0] ORD_N3 = -3'sd3;
  localparam logic signed [2:0] ORD_N2 = -3'sd2;
  localparam logic signed [2:0] ORD_N1 = -3'sd1;
  localparam logic signed [2:0] ORD_Z  = 3'sd0;
  localparam logic signed [2:0] ORD_P1 = 3'sd1;
  localparam logic signed [2:0] ORD_P2 = 3'sd2;

  localparam logic signed [33:0] ONE = 34'sh040000000;

  localparam logic signed [33:0] K_L0   = 34'(64'd28209479  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_L1   = 34'(64'd48860251  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_XY2  = 34'(64'd109254843 * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_Z2   = 34'(64'd31539157  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_XX2  = 34'(64'd54627421  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_33   = 34'(64'd59004358  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_XYZ3 = 34'(64'd289061144 * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_13   = 34'(64'd45704579  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_Z3   = 34'(64'd37317633  * 64'd1073741824 / 64'd100000000);
  localparam logic signed [33:0] K_23   = 34'(64'd144530572 * 64'd1073741824 / 64'd100000000);

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } dir_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic             sx;
    logic             sy;
    logic             sz;
    logic [31:0]      mx;
    logic [31:0]      my;
    logic [31:0]      mz;
  } front_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic             outside;
    logic             zero;
    logic             sx;
    logic             sy;
    logic             sz;
  } mid_t;

  typedef struct packed {
    logic               qv;
    logic               outside;
    logic               clamp;
    logic signed [31:0] a;
    logic               dneg;
    dir_t               dir;
  } tail_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // signed product scaled down by 2^30, truncated toward zero
  function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [65:0] p;
    logic [33:0] t;
    ma = a[33] ? 33'(-a) : 33'(a);
    mb = b[33] ? 33'(-b) : 33'(b);
    p  = 66'(ma) * 66'(mb);
    t  = 34'(p >> 30);
    qmul = (a[33] ^ b[33]) ? -t : t;
  endfunction

endpackage

>>> design/orbital_density_sampler.sv
// orbital_density_sampler: top level, probability density of an orbital at a point
// depends on ods_pkg, ods_ram, ods_sqrt, ods_div, ods_harm
//
// One request is accepted every clock cycle; busy never rises. A table write (kind 0)
// gives no result; a point query (kind 1) gives one result on density_o and outside_o,
// marked by result_valid_o, in request order. A query passes three bit-serial
// pipelines in series: a 32-stage square root, a 32-stage divider for direction and
// table position, and a 32-stage divider for the interpolation fraction. A table
// write lands in the radial sample RAM at the same stage where queries read it, so
// requests see the table in order. The receiver cannot hold results off. The user
// must write configuration only while no request is in flight; the block itself
// does not enforce it.
module orbital_density_sampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [8:0]                      entry_index_i,
  input  logic signed [31:0]              entry_value_i,
  input  logic signed [31:0]              pos_x_i,
  input  logic signed [31:0]              pos_y_i,
  input  logic signed [31:0]              pos_z_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [30:0]                     cfg_data_i,
  output logic                            result_valid_o,
  output logic [47:0]                     density_o,
  output logic                            outside_o
);
  import ods_pkg::*;

  // configuration
  logic [30:0]        rl_q;
  logic [1:0]         deg_q;
  logic signed [2:0]  ord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q  <= '0;
      deg_q <= '0;
      ord_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS_LIMIT: rl_q  <= cfg_data_i;
        REG_DEGREE:       deg_q <= cfg_data_i[1:0];
        REG_ORDER:        ord_q <= signed'(cfg_data_i[2:0]);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front: capture, squares, sum
  front_t      f0_d, f0_q, f1_q, f2_q;
  front_t      fs_q [SQRT_LAT];
  logic [63:0] sqx_q, sqy_q, sqz_q, sum_q;
  logic [31:0] root;

  always_comb begin
    f0_d.valid = start;
    f0_d.kind  = kind_i;
    f0_d.idx   = entry_index_i;
    f0_d.value = entry_value_i;
    f0_d.sx    = pos_x_i[31];
    f0_d.sy    = pos_y_i[31];
    f0_d.sz    = pos_z_i[31];
    f0_d.mx    = mag32(pos_x_i);
    f0_d.my    = mag32(pos_y_i);
    f0_d.mz    = mag32(pos_z_i);
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= 64'(f0_q.mx) * 64'(f0_q.mx);
    sqy_q <= 64'(f0_q.my) * 64'(f0_q.my);
    sqz_q <= 64'(f0_q.mz) * 64'(f0_q.mz);
    sum_q <= sqx_q + sqy_q + sqz_q;
  end

  ods_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (root)
  );

  // direction and table position
  front_t      fr;
  mid_t        b_d, b_q;
  mid_t        fd_q [DIV_LAT];
  logic [63:0] nx_q, ny_q, nz_q, npos_q;
  logic [31:0] dr_q;
  logic [31:0] qx, qy, qz, qpos, fpos, rx, ry, rz;

  assign fr = fs_q[SQRT_LAT-1];

  always_comb begin
    b_d.valid   = fr.valid;
    b_d.kind    = fr.kind;
    b_d.idx     = fr.idx;
    b_d.value   = fr.value;
    b_d.outside = root >= 32'(rl_q);
    b_d.zero    = root == '0;
    b_d.sx      = fr.sx;
    b_d.sy      = fr.sy;
    b_d.sz      = fr.sz;
  end

  always_ff @(posedge clk_i) begin
    nx_q   <= {2'b00, fr.mx, 30'd0};
    ny_q   <= {2'b00, fr.my, 30'd0};
    nz_q   <= {2'b00, fr.mz, 30'd0};
    dr_q   <= (root == '0) ? 32'd1 : root;
    npos_q <= 64'(root) * 64'(TABLE_DEPTH - 1);
  end

  ods_div u_div_x (.clk_i(clk_i), .dividend_i(nx_q), .divisor_i(dr_q),
                   .quo_o(qx), .rem_o(rx));
  ods_div u_div_y (.clk_i(clk_i), .dividend_i(ny_q), .divisor_i(dr_q),
                   .quo_o(qy), .rem_o(ry));
  ods_div u_div_z (.clk_i(clk_i), .dividend_i(nz_q), .divisor_i(dr_q),
                   .quo_o(qz), .rem_o(rz));
  ods_div u_div_pos (.clk_i(clk_i), .dividend_i(npos_q), .divisor_i(32'(rl_q)),
                     .quo_o(qpos), .rem_o(fpos));

  // table access
  mid_t              fm;
  dir_t              dir_d, dir1_q;
  logic              clamp_d, clamp1_q, qv1_q, out1_q;
  logic [31:0]       f1v_q;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic              we;
  logic [31:0]       rd_a, rd_b;

  assign fm = fd_q[DIV_LAT-1];

  always_comb begin
    dir_d.dx = fm.zero ? 32'sd0 : (fm.sx ? -signed'(qx) : signed'(qx));
    dir_d.dy = fm.zero ? 32'sd0 : (fm.sy ? -signed'(qy) : signed'(qy));
    dir_d.dz = fm.zero ? 32'(ONE) : (fm.sz ? -signed'(qz) : signed'(qz));
    clamp_d  = qpos >= 32'(TABLE_DEPTH - 1);
    raddr_a  = clamp_d ? ADDR_W'(TABLE_DEPTH - 1) : qpos[ADDR_W-1:0];
    raddr_b  = qpos[ADDR_W-1:0] + ADDR_W'(1);
    we       = fm.valid && !fm.kind && (CMP_W'(fm.idx) < CMP_W'(TABLE_DEPTH));
  end

  ods_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (ADDR_W'(fm.idx)),
    .wdata_i   (fm.value),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    dir1_q   <= dir_d;
    clamp1_q <= clamp_d;
    f1v_q    <= fpos;
  end

  // interpolation fraction
  tail_t              t_d;
  tail_t              t0_q;
  tail_t              ft_q [DIV_LAT];
  logic signed [32:0] dif;
  logic [31:0]        dmag;
  logic [63:0]        prod_q;
  tail_t              t_last;
  logic [31:0]        tq, tr;

  always_comb begin
    dif        = 33'(signed'(rd_b)) - 33'(signed'(rd_a));
    dmag       = 32'(dif[32] ? -dif : dif);
    t_d.qv      = qv1_q;
    t_d.outside = out1_q;
    t_d.clamp   = clamp1_q;
    t_d.a       = signed'(rd_a);
    t_d.dneg    = dif[32];
    t_d.dir     = dir1_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(dmag) * 64'(f1v_q);
  end

  ods_div u_div_t (.clk_i(clk_i), .dividend_i(prod_q), .divisor_i(32'(rl_q)),
                   .quo_o(tq), .rem_o(tr));

  logic signed [33:0] harm;

  ods_harm u_harm (
    .clk_i    (clk_i),
    .dir_i    (ft_q[DIV_LAT-1-HARM_LAT].dir),
    .degree_i (deg_q),
    .order_i  (ord_q),
    .harm_o   (harm)
  );

  assign t_last = ft_q[DIV_LAT-1];

  // value, product, square
  logic signed [33:0] a_ext, t_ext, vsum;
  logic signed [31:0] val_q;
  logic signed [33:0] h_q;
  logic [65:0]        pprod;
  logic [35:0]        pm_q;
  logic [47:0]        dens_d;
  logic               qv_e1_q, out_e1_q, qv_e2_q, out_e2_q;
  logic               rv_q, ro_q;
  logic [47:0]        rd_q;

  always_comb begin
    a_ext  = 34'(t_last.a);
    t_ext  = signed'({2'b00, tq});
    vsum   = t_last.clamp ? a_ext : (t_last.dneg ? a_ext - t_ext : a_ext + t_ext);
    pprod  = 66'(mag32(val_q)) * 66'(h_q[33] ? 34'(-h_q) : 34'(h_q));
    dens_d = (|pm_q[35:32]) ? '1 : 48'((64'(pm_q[31:0]) * 64'(pm_q[31:0])) >> 16);
  end

  always_ff @(posedge clk_i) begin
    val_q <= 32'(vsum);
    h_q   <= harm;
    pm_q  <= 36'(pprod >> 30);
    rd_q  <= out_e2_q ? '0 : dens_d;
  end

  // control and sideband registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q <= '0;
      f1_q <= '0;
      f2_q <= '0;
      for (int k = 0; k < SQRT_LAT; k++) begin
        fs_q[k] <= '0;
      end
      b_q <= '0;
      for (int k = 0; k < DIV_LAT; k++) begin
        fd_q[k] <= '0;
        ft_q[k] <= '0;
      end
      t0_q     <= '0;
      qv1_q    <= 1'b0;
      out1_q   <= 1'b0;
      qv_e1_q  <= 1'b0;
      out_e1_q <= 1'b0;
      qv_e2_q  <= 1'b0;
      out_e2_q <= 1'b0;
      rv_q     <= 1'b0;
      ro_q     <= 1'b0;
    end else begin
      f0_q <= f0_d;
      f1_q <= f0_q;
      f2_q <= f1_q;
      fs_q[0] <= f2_q;
      for (int k = 1; k < SQRT_LAT; k++) begin
        fs_q[k] <= fs_q[k-1];
      end
      b_q <= b_d;
      fd_q[0] <= b_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        fd_q[k] <= fd_q[k-1];
      end
      qv1_q  <= fm.valid && fm.kind;
      out1_q <= fm.outside;
      t0_q   <= t_d;
      ft_q[0] <= t0_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        ft_q[k] <= ft_q[k-1];
      end
      qv_e1_q  <= t_last.qv;
      out_e1_q <= t_last.outside;
      qv_e2_q  <= qv_e1_q;
      out_e2_q <= out_e1_q;
      rv_q     <= qv_e2_q;
      ro_q     <= out_e2_q;
    end
  end

  assign result_valid_o = rv_q;
  assign density_o      = rd_q;
  assign outside_o      = ro_q;

endmodule

>>> design/ods_ram.sv
// ods_ram: generic synchronous RAM, one write port and two registered read ports
// no dependencies
module ods_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> design/ods_sqrt.sv
// ods_sqrt: pipelined integer square root, one result bit per stage
// depends on ods_pkg
module ods_sqrt (
  input  logic        clk_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import ods_pkg::*;

  logic [63:0] rad_q  [SQRT_LAT];
  logic [34:0] rem_q  [SQRT_LAT];
  logic [31:0] root_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [63:0] rad_in;
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[32:0], rad_in[63:62]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[61:0], 2'b00};
      rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
      root_q[k] <= {root_in[30:0], ge};
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

>>> design/ods_div.sv
// ods_div: pipelined restoring divider, 64 by 32 bits, one quotient bit per stage
// depends on ods_pkg; the upper dividend half must be below the divisor
module ods_div (
  input  logic        clk_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  import ods_pkg::*;

  logic [31:0] num_q [DIV_LAT];
  logic [31:0] rem_q [DIV_LAT];
  logic [31:0] div_q [DIV_LAT];
  logic [31:0] quo_q [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [31:0] num_in;
    logic [31:0] rem_in;
    logic [31:0] div_in;
    logic [31:0] quo_in;
    logic [32:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign num_in = dividend_i[31:0];
      assign rem_in = dividend_i[63:32];
      assign div_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, num_in[31]};
    assign ge    = trial >= {1'b0, div_in};

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[30:0], 1'b0};
      rem_q[k] <= ge ? 32'(trial - {1'b0, div_in}) : trial[31:0];
      div_q[k] <= div_in;
      quo_q[k] <= {quo_in[30:0], ge};
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign rem_o = rem_q[DIV_LAT-1];

endmodule

>>> design/ods_harm.sv
// ods_harm: pipelined real spherical harmonic of degree 0..3 at a unit direction
// depends on ods_pkg
module ods_harm (
  input  logic                      clk_i,
  input  ods_pkg::dir_t             dir_i,
  input  logic [1:0]                degree_i,
  input  logic signed [2:0]         order_i,
  output logic signed [33:0]        harm_o
);
  import ods_pkg::*;

  logic signed [33:0] x_q, y_q, z_q, xx_q, yy_q, zz_q, xy_q;
  logic signed [33:0] p_d, q_d, k_d;
  logic signed [33:0] p_q, q_q, k_q;
  logic signed [33:0] w_q, k2_q, h_q;
  logic signed [33:0] xs, ys, zs;

  assign xs = 34'(dir_i.dx);
  assign ys = 34'(dir_i.dy);
  assign zs = 34'(dir_i.dz);

  always_comb begin
    p_d = ONE;
    q_d = ONE;
    k_d = K_L0;
    unique case (degree_i)
      DEG_S: begin
        k_d = K_L0;
      end
      DEG_P: begin
        k_d = K_L1;
        case (order_i)
          ORD_N1:  p_d = y_q;
          ORD_Z:   p_d = z_q;
          default: p_d = x_q;
        endcase
      end
      DEG_D: begin
        case (order_i)
          ORD_N2: begin
            k_d = K_XY2; p_d = x_q; q_d = y_q;
          end
          ORD_N1: begin
            k_d = K_XY2; p_d = y_q; q_d = z_q;
          end
          ORD_Z: begin
            k_d = K_Z2; p_d = 34'(3 * zz_q) - ONE;
          end
          ORD_P1: begin
            k_d = K_XY2; p_d = x_q; q_d = z_q;
          end
          default: begin
            k_d = K_XX2; p_d = xx_q - yy_q;
          end
        endcase
      end
      DEG_F: begin
        case (order_i)
          ORD_N3: begin
            k_d = K_33; p_d = y_q; q_d = 34'(3 * xx_q) - yy_q;
          end
          ORD_N2: begin
            k_d = K_XYZ3; p_d = xy_q; q_d = z_q;
          end
          ORD_N1: begin
            k_d = K_13; p_d = y_q; q_d = 34'(5 * zz_q) - ONE;
          end
          ORD_Z: begin
            k_d = K_Z3; p_d = z_q; q_d = 34'(5 * zz_q) - 34'(3 * ONE);
          end
          ORD_P1: begin
            k_d = K_13; p_d = x_q; q_d = 34'(5 * zz_q) - ONE;
          end
          ORD_P2: begin
            k_d = K_23; p_d = xx_q - yy_q; q_d = z_q;
          end
          default: begin
            k_d = K_33; p_d = x_q; q_d = xx_q - 34'(3 * yy_q);
          end
        endcase
      end
      default: begin
        k_d = K_L0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q  <= xs;
    y_q  <= ys;
    z_q  <= zs;
    xx_q <= qmul(xs, xs);
    yy_q <= qmul(ys, ys);
    zz_q <= qmul(zs, zs);
    xy_q <= qmul(xs, ys);
    p_q  <= p_d;
    q_q  <= q_d;
    k_q  <= k_d;
    w_q  <= qmul(p_q, q_q);
    k2_q <= k_q;
    h_q  <= qmul(k2_q, w_q);
  end

  assign harm_o = h_q;

endmodule
